// ===== rtl/core/dfd_pkg.sv =====
// Shared types and constants for the deauthentication flood detector.
`default_nettype none
package dfd_pkg;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 48;

	localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_US      = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_SENSOR_ADDRESS = 2'd1;

	localparam logic [31:0] WINDOW_US_RESET = 32'd500000;

	localparam logic [1:0] FC_TYPE_MGMT      = 2'h0;
	localparam logic [3:0] FC_SUBTYPE_DEAUTH = 4'hC;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UPD,
		ST_CMP,
		ST_WAIT,
		ST_APPEND,
		ST_CHECK,
		ST_DIV,
		ST_EMIT
	} dfd_state_t;

	typedef struct packed {
		logic capture;
		logic str_upd;
		logic drop;
		logic append;
		logic alarm_start;
		logic div_step;
		logic emit;
	} dp_cmd_t;

	typedef struct packed {
		logic match;
		logic prune_ok;
		logic alarm_hit;
		logic div_done;
		logic out_free;
	} dp_sts_t;

	function automatic logic is_deauth(input logic mgmt, input logic [7:0] fcl);
		is_deauth = mgmt && (fcl[3:2] == FC_TYPE_MGMT) && (fcl[7:4] == FC_SUBTYPE_DEAUTH);
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/dfd_ctrl.sv =====
// Sequencer for frame update, prune walk, alarm check, divide and emit.
`default_nettype none
module dfd_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire dfd_pkg::dp_sts_t sts,
	output dfd_pkg::dp_cmd_t      cmd
);
	import dfd_pkg::*;

	dfd_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				// non-matching beats are taken and dropped here
				if (in_valid && sts.match) begin
					cmd.capture = 1'b1;
					state_d     = ST_UPD;
				end
			end
			ST_UPD: begin
				cmd.str_upd = 1'b1;
				state_d     = ST_CMP;
			end
			ST_CMP: begin
				if (sts.prune_ok) begin
					cmd.drop = 1'b1;
					state_d  = ST_WAIT;
				end else begin
					state_d = ST_APPEND;
				end
			end
			// time at the new oldest slot is read here for the next compare
			ST_WAIT: state_d = ST_CMP;
			ST_APPEND: begin
				cmd.append = 1'b1;
				state_d    = ST_CHECK;
			end
			ST_CHECK: begin
				if (sts.alarm_hit) begin
					cmd.alarm_start = 1'b1;
					state_d         = ST_DIV;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_DIV: begin
				if (sts.div_done) begin
					state_d = ST_EMIT;
				end else begin
					cmd.div_step = 1'b1;
				end
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule
`default_nettype wire

// ===== rtl/core/dfd_datapath.sv =====
// Datapath: config registers, strength and time rings, running sum, divider, output register.
`default_nettype none
module dfd_datapath #(
	parameter int ALARM_COUNT = 50,
	parameter int TIME_DEPTH  = 1024
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_write_en,
	input  wire logic [dfd_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  wire logic [dfd_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  wire logic                               is_management,
	input  wire logic [7:0]                         frame_ctrl_low,
	input  wire logic [47:0]                        sender_address,
	input  wire logic signed [7:0]                  signal_strength,
	input  wire logic [62:0]                        timestamp_us,
	input  wire logic                               out_stall,
	output logic                                    out_valid,
	output logic [47:0]                             attacker_address,
	output logic [47:0]                             reporting_address,
	output logic signed [7:0]                       average_strength,
	input  wire dfd_pkg::dp_cmd_t                   cmd,
	output dfd_pkg::dp_sts_t                        sts
);
	import dfd_pkg::*;

	localparam int TW   = $clog2(TIME_DEPTH);
	localparam int SIW  = (ALARM_COUNT > 1) ? $clog2(ALARM_COUNT) : 1;
	localparam int MW   = $clog2(128 * ALARM_COUNT + 1);
	localparam int SUMW = MW + 1;
	localparam int DSH  = MW + $clog2(ALARM_COUNT);
	localparam int RCW  = DSH + 1;

	localparam logic [TW-1:0]  T_LAST = TW'(TIME_DEPTH - 1);
	localparam logic [SIW-1:0] S_LAST = SIW'(ALARM_COUNT - 1);
	// ceil(2**DSH / ALARM_COUNT): exact quotient for every dividend below 2**MW
	localparam logic [RCW-1:0] RECIP  = RCW'((2 ** DSH + ALARM_COUNT - 1) / ALARM_COUNT);

	function automatic logic [TW-1:0] t_next(input logic [TW-1:0] p);
		t_next = (p == T_LAST) ? '0 : p + 1'b1;
	endfunction

	// configuration
	logic [31:0] window_q;
	logic [47:0] sensor_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WINDOW_US_RESET;
			sensor_q <= '0;
		end else if (cfg_write_en) begin
			case (cfg_index)
				REG_WINDOW_US:      window_q <= cfg_data[31:0];
				REG_SENSOR_ADDRESS: sensor_q <= cfg_data[47:0];
				default: ;
			endcase
		end
	end

	// captured beat
	logic [62:0]       ts_q;
	logic [47:0]       sender_q;
	logic signed [7:0] str_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			ts_q     <= timestamp_us;
			sender_q <= sender_address;
			str_q    <= signal_strength;
		end
	end

	// strength ring with per-entry valid bits; unwritten entries read as zero
	logic [7:0]             str_mem [ALARM_COUNT];
	logic [7:0]             s_rd_q;
	logic [ALARM_COUNT-1:0] s_vld_q;
	logic [SIW-1:0]         sidx_q;
	logic signed [SUMW-1:0] sum_q;
	logic [7:0]             s_old;

	always_ff @(posedge clk) begin
		if (cmd.str_upd) begin
			str_mem[sidx_q] <= str_q;
		end
		s_rd_q <= str_mem[sidx_q];
	end

	assign s_old = s_vld_q[sidx_q] ? s_rd_q : 8'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_vld_q <= '0;
			sidx_q  <= '0;
			sum_q   <= '0;
		end else if (cmd.alarm_start) begin
			s_vld_q <= '0;
			sidx_q  <= '0;
			sum_q   <= '0;
		end else if (cmd.str_upd) begin
			s_vld_q[sidx_q] <= 1'b1;
			sidx_q          <= (sidx_q == S_LAST) ? '0 : sidx_q + 1'b1;
			sum_q           <= sum_q + {{(SUMW-8){str_q[7]}}, str_q}
			                         - {{(SUMW-8){s_old[7]}}, s_old};
		end
	end

	// time ring
	logic [62:0]   time_mem [TIME_DEPTH];
	logic [62:0]   t_rd_q;
	logic [TW-1:0] oldest_q;
	logic [TW-1:0] newest_q;
	logic [TW-1:0] newest_nx;
	logic [TW-1:0] count;
	logic [63:0]   t_limit;

	always_ff @(posedge clk) begin
		if (cmd.append) begin
			time_mem[newest_q] <= ts_q;
		end
		t_rd_q <= time_mem[oldest_q];
	end

	assign newest_nx = t_next(newest_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oldest_q <= '0;
			newest_q <= '0;
		end else if (cmd.alarm_start) begin
			oldest_q <= '0;
			newest_q <= '0;
		end else if (cmd.drop) begin
			oldest_q <= t_next(oldest_q);
		end else if (cmd.append) begin
			// ring full: free the oldest slot first
			if (newest_nx == oldest_q) begin
				oldest_q <= t_next(oldest_q);
			end
			newest_q <= newest_nx;
		end
	end

	assign t_limit = {1'b0, t_rd_q} + {32'd0, window_q};
	assign count   = (newest_q >= oldest_q) ? newest_q - oldest_q
	                                        : newest_q + T_LAST + 1'b1 - oldest_q;

	// |sum| / ALARM_COUNT by reciprocal multiply: load, then a registered multiply
	logic              neg_q;
	logic [MW-1:0]     dvd_q;
	logic [MW-1:0]     quo_q;
	logic              div_rdy_q;
	logic [SUMW-1:0]   sum_neg;
	logic [MW-1:0]     quo_neg;
	logic [MW+RCW-1:0] prod;

	assign sum_neg = -sum_q;
	assign prod    = dvd_q * RECIP;
	assign quo_neg = -quo_q;

	always_ff @(posedge clk) begin
		if (cmd.alarm_start) begin
			neg_q     <= sum_q[SUMW-1];
			dvd_q     <= sum_q[SUMW-1] ? sum_neg[MW-1:0] : sum_q[MW-1:0];
			div_rdy_q <= 1'b0;
		end else if (cmd.div_step) begin
			quo_q     <= prod[DSH +: MW];
			div_rdy_q <= 1'b1;
		end
	end

	// output register
	logic        out_valid_q;
	logic [47:0] attacker_q;
	logic [47:0] reporting_q;
	logic [7:0]  avg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			attacker_q  <= sender_q;
			reporting_q <= sensor_q;
			avg_q       <= neg_q ? quo_neg[7:0] : quo_q[7:0];
		end
	end

	assign out_valid         = out_valid_q;
	assign attacker_address  = attacker_q;
	assign reporting_address = reporting_q;
	assign average_strength  = avg_q;

	always_comb begin
		sts           = '0;
		sts.match     = is_deauth(is_management, frame_ctrl_low);
		sts.prune_ok  = (oldest_q != newest_q) && (t_limit < {1'b0, ts_q});
		sts.alarm_hit = ({1'b0, count} >= (TW + 1)'(ALARM_COUNT));
		sts.div_done  = div_rdy_q;
		sts.out_free  = !out_valid_q || !out_stall;
	end

endmodule
`default_nettype wire

// ===== rtl/core/deauth_flood_detector_unit.sv =====
// Top level of the deauthentication flood detector.
//
// Takes one received frame per beat and raises an alarm beat when ALARM_COUNT deauth frames
// fall within window_us microseconds. Frames that are not management type 0 subtype 12 are
// accepted without holding the input and leave no trace. A deauth frame holds the input
// through the strength update, the prune walk that drops stale timestamps off the time ring
// (one registered memory read and one add-and-compare per step), the append and the alarm
// check. A frame that fires the alarm also holds it for the load and reciprocal multiply that
// form the average and for the output load, and waits while a previous alarm beat still
// sits stalled in the output register. The strength store resets through per-entry valid
// bits, so no clearing pass follows reset. Write configuration only while the block is idle.
`default_nettype none
module deauth_flood_detector_unit #(
	parameter int ALARM_COUNT = 50,
	parameter int TIME_DEPTH  = 1024
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_write_en,
	input  wire logic [dfd_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [dfd_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic                            is_management,
	input  wire logic [7:0]                      frame_ctrl_low,
	// second frame-control byte plays no part in the decision
	input  wire logic [7:0]                      frame_ctrl_high,
	input  wire logic [47:0]                     sender_address,
	input  wire logic signed [7:0]               signal_strength,
	input  wire logic [62:0]                     timestamp_us,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic [47:0]                          attacker_address,
	output logic [47:0]                          reporting_address,
	output logic signed [7:0]                    average_strength
);
	import dfd_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	dfd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	dfd_datapath #(
		.ALARM_COUNT (ALARM_COUNT),
		.TIME_DEPTH  (TIME_DEPTH)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_write_en      (cfg_write_en),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.is_management     (is_management),
		.frame_ctrl_low    (frame_ctrl_low),
		.sender_address    (sender_address),
		.signal_strength   (signal_strength),
		.timestamp_us      (timestamp_us),
		.out_stall         (out_stall),
		.out_valid         (out_valid),
		.attacker_address  (attacker_address),
		.reporting_address (reporting_address),
		.average_strength  (average_strength),
		.cmd               (cmd),
		.sts               (sts)
	);

endmodule
`default_nettype wire

// ===== rtl/core/dfd_checker.sv =====
// Port-level checks for the flood detector, bound to the top level.
`default_nettype none
module dfd_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic        is_management,
	input wire logic [7:0]  frame_ctrl_low,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [47:0] attacker_address,
	input wire logic [47:0] reporting_address,
	input wire logic [7:0]  average_strength
);
	import dfd_pkg::*;

	logic deauth_beat;
	logic other_beat;

	assign deauth_beat = in_valid && !in_stall && is_deauth(is_management, frame_ctrl_low);
	assign other_beat  = in_valid && !in_stall && !deauth_beat;

	// a deauth beat always starts the update sequence
	a_deauth_busy: assert property (@(posedge clk) disable iff (!arst_n)
		deauth_beat |=> in_stall)
		else $error("input not held after deauth beat");

	// other frames are dropped without holding the input
	a_other_free: assert property (@(posedge clk) disable iff (!arst_n)
		other_beat |=> !in_stall)
		else $error("input held after non-deauth beat");

	// a new alarm appears only after the block has been busy with a frame
	a_alarm_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("alarm beat without a processed frame");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(attacker_address) &&
		$stable(reporting_address) && $stable(average_strength))
		else $error("stalled alarm beat changed");

endmodule

bind deauth_flood_detector_unit dfd_checker u_dfd_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.in_valid          (in_valid),
	.in_stall          (in_stall),
	.is_management     (is_management),
	.frame_ctrl_low    (frame_ctrl_low),
	.out_valid         (out_valid),
	.out_stall         (out_stall),
	.attacker_address  (attacker_address),
	.reporting_address (reporting_address),
	.average_strength  (average_strength)
);
`default_nettype wire
